// ===== design/tablet_aspect_calibrated_mapper_defines.svh =====
// Assertion helpers shared by the mapper RTL.
`ifndef TABLET_ASPECT_CALIBRATED_MAPPER_DEFINES_SVH
`define TABLET_ASPECT_CALIBRATED_MAPPER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TACM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define TACM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/tacm_pkg.sv =====
package tacm_pkg;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TABLET_MIN_X  = 3'd0,
    REG_TABLET_MAX_X  = 3'd1,
    REG_TABLET_MIN_Y  = 3'd2,
    REG_TABLET_MAX_Y  = 3'd3,
    REG_SCREEN_WIDTH  = 3'd4,
    REG_SCREEN_HEIGHT = 3'd5,
    REG_ASPECT_ENABLE = 3'd6
  } cfg_reg_t;

  // Box narrower than 1/THIN_RATIO of a unit is rejected.
  localparam int THIN_RATIO = 100;

  localparam int RST_TABLET_MAX  = 4095;
  localparam int RST_SCREEN_W    = 1920;
  localparam int RST_SCREEN_H    = 1080;

endpackage

// ===== design/tacm_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// rem_in must be below den; quotient = ({rem_in, low_in}) / den.
module tacm_div #(
  parameter int DW = 31,
  parameter int QW = 22
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] rem_in,
  input  logic [QW-1:0] low_in,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] q
);

  logic [DW-1:0] rem [0:QW];
  logic [QW-1:0] low [0:QW];
  logic [DW-1:0] dn  [0:QW];
  logic [QW-1:0] qq  [0:QW];

  assign rem[0] = rem_in;
  assign low[0] = low_in;
  assign dn[0]  = den;
  assign qq[0]  = '0;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;

    assign trial = {rem[k], low[k][QW-1]};
    assign diff  = trial - {1'b0, dn[k]};
    assign ge    = trial >= {1'b0, dn[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        low[k+1] <= low[k] << 1;
        dn[k+1]  <= dn[k];
        qq[k+1]  <= {qq[k][QW-2:0], ge};
      end
    end
  end

  assign q = qq[QW];

endmodule

// ===== design/tablet_aspect_calibrated_mapper.sv =====
// Throughput: one request per cycle; six arithmetic stages feed a one-bit-per-stage
// divider per axis, and the whole pipeline holds while the output waits.
// Reset: rst (synchronous) clears all valid bits and restores the register defaults.
module tablet_aspect_calibrated_mapper #(
  parameter int AXIS_BITS   = 16,
  parameter int SCREEN_BITS = 13,
  parameter int FRAC_BITS   = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [tacm_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [((AXIS_BITS > SCREEN_BITS + 1) ? AXIS_BITS : SCREEN_BITS + 1)-1:0] cfg_wdata,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // pos_x, pos_y
  input  logic [((2*AXIS_BITS+7)/8)*8-1:0]  s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // screen_x, screen_y
  output logic [((2*(SCREEN_BITS+FRAC_BITS)+7)/8)*8-1:0] m_axis_tdata,
  // rotated, valid_res
  output logic [1:0]                        m_axis_tuser
);

  localparam int A     = AXIS_BITS;
  localparam int SCR_W = SCREEN_BITS + 1;
  localparam int P     = A + SCR_W;
  localparam int DW    = P + 1;
  localparam int SXW   = P + 3;
  localparam int MW    = P + 7;
  localparam int PW    = DW + SCR_W;
  localparam int QW    = SCR_W + FRAC_BITS;
  localparam int OW    = SCREEN_BITS + FRAC_BITS;
  localparam int OUT_W = ((2*OW+7)/8)*8;
  localparam int LAT   = 6 + QW + 1;

  // configuration
  logic [A-1:0]     min_x, max_x, min_y, max_y;
  logic [SCR_W-1:0] scr_w, scr_h;
  logic             asp_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_x  <= '0;
      max_x  <= A'(tacm_pkg::RST_TABLET_MAX);
      min_y  <= '0;
      max_y  <= A'(tacm_pkg::RST_TABLET_MAX);
      scr_w  <= SCR_W'(tacm_pkg::RST_SCREEN_W);
      scr_h  <= SCR_W'(tacm_pkg::RST_SCREEN_H);
      asp_en <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        tacm_pkg::REG_TABLET_MIN_X:  min_x  <= cfg_wdata[A-1:0];
        tacm_pkg::REG_TABLET_MAX_X:  max_x  <= cfg_wdata[A-1:0];
        tacm_pkg::REG_TABLET_MIN_Y:  min_y  <= cfg_wdata[A-1:0];
        tacm_pkg::REG_TABLET_MAX_Y:  max_y  <= cfg_wdata[A-1:0];
        tacm_pkg::REG_SCREEN_WIDTH:  scr_w  <= cfg_wdata[SCR_W-1:0];
        tacm_pkg::REG_SCREEN_HEIGHT: scr_h  <= cfg_wdata[SCR_W-1:0];
        tacm_pkg::REG_ASPECT_ENABLE: asp_en <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic [LAT-1:0] vld;
  logic           en;

  assign en            = !vld[LAT-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_axis_tvalid};
    end
  end

  logic [A-1:0] pos_x, pos_y;
  assign pos_x = s_axis_tdata[A-1:0];
  assign pos_y = s_axis_tdata[2*A-1:A];

  // stage 1: tablet size, orientation, crop ratio
  logic [A-1:0]     s1_px, s1_py, s1_tw, s1_th;
  logic [SCR_W-1:0] s1_a, s1_b;
  logic             s1_bad, s1_rot, s1_crop;
  logic [A-1:0]     tw_c, th_c;
  logic             rot_c;

  assign tw_c  = max_x - min_x;
  assign th_c  = max_y - min_y;
  assign rot_c = (tw_c > th_c && scr_w < scr_h) || (tw_c < th_c && scr_w > scr_h);

  always_ff @(posedge clk) begin
    if (en) begin
      s1_px   <= pos_x;
      s1_py   <= pos_y;
      s1_tw   <= tw_c;
      s1_th   <= th_c;
      s1_bad  <= (max_x <= min_x) || (max_y <= min_y);
      s1_rot  <= rot_c;
      s1_crop <= asp_en && scr_w != '0 && scr_h != '0;
      s1_a    <= rot_c ? scr_h : scr_w;
      s1_b    <= rot_c ? scr_w : scr_h;
    end
  end

  // stage 2: cross products
  logic [A-1:0]     s2_px, s2_py, s2_tw, s2_th;
  logic [SCR_W-1:0] s2_a, s2_b;
  logic             s2_bad, s2_rot, s2_crop;
  logic [P-1:0]     s2_tb, s2_ta, s2_bpx, s2_apy;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_px   <= s1_px;
      s2_py   <= s1_py;
      s2_tw   <= s1_tw;
      s2_th   <= s1_th;
      s2_a    <= s1_a;
      s2_b    <= s1_b;
      s2_bad  <= s1_bad;
      s2_rot  <= s1_rot;
      s2_crop <= s1_crop;
      s2_tb   <= P'(s1_tw) * P'(s1_b);
      s2_ta   <= P'(s1_th) * P'(s1_a);
      s2_bpx  <= P'(s1_px) * P'(s1_b);
      s2_apy  <= P'(s1_py) * P'(s1_a);
    end
  end

  // stage 3: crop axis, thin-box check, shifted positions
  logic [A-1:0]          s3_px, s3_py, s3_tw, s3_th;
  logic [P-1:0]          s3_tb, s3_ta;
  logic                  s3_bad, s3_rot, s3_crop, s3_cropx, s3_thin;
  logic signed [SXW-1:0] s3_sx, s3_sy;
  logic                  cropx_c;

  assign cropx_c = s2_tb > s2_ta;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_px    <= s2_px;
      s3_py    <= s2_py;
      s3_tw    <= s2_tw;
      s3_th    <= s2_th;
      s3_tb    <= s2_tb;
      s3_ta    <= s2_ta;
      s3_bad   <= s2_bad;
      s3_rot   <= s2_rot;
      s3_crop  <= s2_crop;
      s3_cropx <= cropx_c;
      s3_thin  <= cropx_c ? (MW'(s2_ta) * MW'(tacm_pkg::THIN_RATIO) < MW'(s2_b))
                          : (MW'(s2_tb) * MW'(tacm_pkg::THIN_RATIO) < MW'(s2_a));
      s3_sx    <= $signed((SXW'(s2_bpx) << 1) + SXW'(s2_ta) - SXW'(s2_tb));
      s3_sy    <= $signed((SXW'(s2_apy) << 1) + SXW'(s2_tb) - SXW'(s2_ta));
    end
  end

  // stage 4: box and clamp
  logic [DW-1:0] s4_nx, s4_ny, s4_dx, s4_dy;
  logic          s4_inv, s4_rot;
  logic [DW-1:0] dx_c, dy_c, nx_c, ny_c;
  logic [A-1:0]  px_cl, py_cl;

  always_comb begin
    px_cl = (s3_px > s3_tw) ? s3_tw : s3_px;
    py_cl = (s3_py > s3_th) ? s3_th : s3_py;
    dx_c  = DW'(s3_tw);
    dy_c  = DW'(s3_th);
    nx_c  = DW'(px_cl);
    ny_c  = DW'(py_cl);
    if (s3_crop && s3_cropx) begin
      dx_c = {s3_ta, 1'b0};
      if (s3_sx < 0)                  nx_c = '0;
      else if (s3_sx > SXW'(dx_c))    nx_c = dx_c;
      else                            nx_c = s3_sx[DW-1:0];
    end else if (s3_crop) begin
      dy_c = {s3_tb, 1'b0};
      if (s3_sy < 0)                  ny_c = '0;
      else if (s3_sy > SXW'(dy_c))    ny_c = dy_c;
      else                            ny_c = s3_sy[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_nx  <= nx_c;
      s4_ny  <= ny_c;
      s4_dx  <= dx_c;
      s4_dy  <= dy_c;
      s4_inv <= s3_bad || (s3_crop && s3_thin);
      s4_rot <= s3_rot;
    end
  end

  // stage 5: route axes to outputs
  logic [DW-1:0]    s5_n0, s5_n1, s5_d0, s5_d1;
  logic             s5_inv, s5_rot;
  logic [SCR_W-1:0] s5_sw, s5_sh;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_inv <= s4_inv;
      s5_rot <= s4_rot;
      s5_sw  <= scr_w;
      s5_sh  <= scr_h;
      if (s4_inv) begin
        s5_n0 <= '0;
        s5_n1 <= '0;
        s5_d0 <= DW'(1);
        s5_d1 <= DW'(1);
      end else if (s4_rot) begin
        s5_n0 <= s4_dy - s4_ny;
        s5_d0 <= s4_dy;
        s5_n1 <= s4_nx;
        s5_d1 <= s4_dx;
      end else begin
        s5_n0 <= s4_nx;
        s5_d0 <= s4_dx;
        s5_n1 <= s4_ny;
        s5_d1 <= s4_dy;
      end
    end
  end

  // stage 6: scale by screen size
  logic [PW-1:0] s6_p0, s6_p1;
  logic [DW-1:0] s6_d0, s6_d1;
  logic          s6_inv, s6_rot;

  always_ff @(posedge clk) begin
    if (en) begin
      s6_p0  <= PW'(s5_n0) * PW'(s5_sw);
      s6_p1  <= PW'(s5_n1) * PW'(s5_sh);
      s6_d0  <= s5_d0;
      s6_d1  <= s5_d1;
      s6_inv <= s5_inv;
      s6_rot <= s5_rot;
    end
  end

  // divide: high part of the product is already below the divisor
  logic [QW-1:0] q0, q1;

  tacm_div #(.DW(DW), .QW(QW)) u_div_x (
    .clk    (clk),
    .en     (en),
    .rem_in (s6_p0[PW-1:SCR_W]),
    .low_in (QW'(s6_p0[SCR_W-1:0]) << FRAC_BITS),
    .den    (s6_d0),
    .q      (q0)
  );

  tacm_div #(.DW(DW), .QW(QW)) u_div_y (
    .clk    (clk),
    .en     (en),
    .rem_in (s6_p1[PW-1:SCR_W]),
    .low_in (QW'(s6_p1[SCR_W-1:0]) << FRAC_BITS),
    .den    (s6_d1),
    .q      (q1)
  );

  logic [QW-1:0] inv_pipe, rot_pipe;

  always_ff @(posedge clk) begin
    if (en) begin
      inv_pipe <= {inv_pipe[QW-2:0], s6_inv};
      rot_pipe <= {rot_pipe[QW-2:0], s6_rot};
    end
  end

  // output register: saturate and mask
  logic [OW-1:0] out_x, out_y;
  logic          out_rot, out_ok;

  always_ff @(posedge clk) begin
    if (en) begin
      out_ok  <= !inv_pipe[QW-1];
      out_rot <= !inv_pipe[QW-1] && rot_pipe[QW-1];
      if (inv_pipe[QW-1]) begin
        out_x <= '0;
        out_y <= '0;
      end else begin
        out_x <= q0[QW-1] ? '1 : q0[OW-1:0];
        out_y <= q1[QW-1] ? '1 : q1[OW-1:0];
      end
    end
  end

  assign m_axis_tdata = OUT_W'({out_y, out_x});
  assign m_axis_tuser = {out_ok, out_rot};

`include "tablet_aspect_calibrated_mapper_defines.svh"

  `TACM_ASSERT_NOW(a_inv_zero, m_axis_tvalid && !m_axis_tuser[1], m_axis_tdata == '0 && !m_axis_tuser[0], "rejected result carries nonzero fields")
  `TACM_ASSERT_NEXT(a_hold_vld, !en, $stable(vld), "valid bits moved during stall")
  `TACM_ASSERT_NEXT(a_enter, s_axis_tvalid && s_axis_tready, vld[0], "accepted request not captured")

endmodule
